[sv/led_strip_effect_generator_top_macros.svh]
// Assertion helpers used by the checker file of this block.
`ifndef LED_STRIP_EFFECT_GENERATOR_TOP_MACROS_SVH
`define LED_STRIP_EFFECT_GENERATOR_TOP_MACROS_SVH

// Checked at every rising clock edge, skipped while reset is high.
`define LSEG_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define LSEG_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/lseg_pkg.sv]
package lseg_pkg;

   // Field widths.
   localparam int TimeW    = 32;
   localparam int ChanW    = 8;
   localparam int ColorW   = 24;
   localparam int PixW     = 6;
   localparam int LevelW   = 8;
   localparam int RspDataW = 32;
   localparam int CsrAddrW = 2;
   localparam int CsrDataW = 24;

   // Effect modes.
   typedef enum logic [1:0] {
      MODE_SOLID    = 2'd0,
      MODE_BREATH   = 2'd1,
      MODE_GRADIENT = 2'd2,
      MODE_PULSE    = 2'd3
   } mode_type;

   // Control register indexes.
   typedef enum logic [CsrAddrW-1:0] {
      CSR_EFFECT_MODE = 2'd0,
      CSR_BASE_COLOR  = 2'd1,
      CSR_BRIGHTNESS  = 2'd2,
      CSR_POWER_ON    = 2'd3
   } csr_index_type;

   // Update intervals in milliseconds.
   localparam logic [TimeW-1:0] IntervalSolid    = 32'd1000000;
   localparam logic [TimeW-1:0] IntervalBreath   = 32'd30;
   localparam logic [TimeW-1:0] IntervalGradient = 32'd1000;
   localparam logic [TimeW-1:0] IntervalPulse    = 32'd80;

   // Breathing level limits.
   localparam logic [LevelW-1:0] BreathReset = 8'd128;
   localparam logic [LevelW-1:0] BreathStep  = 8'd3;
   localparam logic [LevelW-1:0] BreathMax   = 8'd255;
   localparam logic [LevelW-1:0] BreathMin   = 8'd30;
   localparam logic [LevelW-1:0] BreathTurn  = 8'd33;

   // Pulse falloff levels by distance from the center.
   localparam logic [LevelW-1:0] PulseLevel0   = 8'd255;
   localparam logic [LevelW-1:0] PulseLevel1   = 8'd128;
   localparam logic [LevelW-1:0] PulseLevel2   = 8'd64;
   localparam logic [LevelW-1:0] PulseLevelFar = 8'd16;
   localparam logic [LevelW-1:0] LevelFull     = 8'd255;

   // Frame queue between front and back.
   localparam int QueueDepth = 2;

   // One frame to render, as the front hands it to the back.
   typedef struct packed {
      mode_type              mode;
      logic [LevelW-1:0]     level;
      logic [PixW-1:0]       pulse_pos;
      logic [ColorW-1:0]     color;
   } cmd_type;

endpackage

[sv/lseg_queue.sv]
module lseg_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lseg_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              pop_valid,
   output lseg_pkg::cmd_type pop_cmd
);
   import lseg_pkg::*;

   localparam int PtrW = $clog2(QueueDepth);
   localparam int CntW = $clog2(QueueDepth + 1);

   cmd_type           mem_ff [QueueDepth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic              do_push, do_pop;

   // Status and read side.
   assign full      = (count_ff == CntW'(QueueDepth));
   assign pop_valid = (count_ff != '0);
   assign pop_cmd   = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   // Pointer and count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      priority if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[sv/lseg_front.sv]
module lseg_front #(
   parameter int NUM_LEDS = 6
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [lseg_pkg::TimeW-1:0]      req_tdata,
   input  logic                            csr_we,
   input  logic [lseg_pkg::CsrAddrW-1:0]   csr_addr,
   input  logic [lseg_pkg::CsrDataW-1:0]   csr_wdata,
   input  logic                            q_full,
   output logic                            q_push,
   output lseg_pkg::cmd_type               q_cmd
);
   import lseg_pkg::*;

   localparam logic [PixW-1:0] PosLast = PixW'(NUM_LEDS - 1);

   // Settings.
   mode_type             mode_ff, mode_in;
   logic [ColorW-1:0]    color_ff, color_in;
   logic [ChanW-1:0]     bright_ff, bright_in;
   logic                 power_ff, power_in;

   // Effect state.
   logic [TimeW-1:0]     last_time_ff, last_time_in;
   logic [LevelW-1:0]    breath_ff, breath_in;
   logic                 rising_ff, rising_in;
   logic [PixW-1:0]      pos_ff, pos_in;
   logic                 falling_ff, falling_in;

   logic [TimeW-1:0]     delta;
   logic [TimeW-1:0]     interval;
   logic                 update_ok;
   logic [LevelW:0]      breath_sum;
   logic [LevelW-1:0]    breath_next;
   logic                 rising_next;
   logic [PixW-1:0]      pos_next;
   logic                 falling_next;

   // Decide whether this time stamp triggers a frame.
   always_comb begin
      delta = req_tdata - last_time_ff;
      unique case (mode_ff)
         MODE_SOLID:    interval = IntervalSolid;
         MODE_BREATH:   interval = IntervalBreath;
         MODE_GRADIENT: interval = IntervalGradient;
         MODE_PULSE:    interval = IntervalPulse;
      endcase
      update_ok = power_ff && (bright_ff != '0) && (delta >= interval);
   end

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full && update_ok;

   // Next breathing level, bouncing between its limits.
   always_comb begin
      breath_sum = {1'b0, breath_ff} + {1'b0, BreathStep};
      if (rising_ff) begin
         if (breath_sum >= {1'b0, BreathMax}) begin
            breath_next = BreathMax;
            rising_next = 1'b0;
         end else begin
            breath_next = breath_sum[LevelW-1:0];
            rising_next = 1'b1;
         end
      end else begin
         if (breath_ff <= BreathTurn) begin
            breath_next = BreathMin;
            rising_next = 1'b1;
         end else begin
            breath_next = breath_ff - BreathStep;
            rising_next = 1'b0;
         end
      end
   end

   // Next pulse center; it turns at the far end and at zero.
   always_comb begin
      pos_next = falling_ff ? pos_ff - 1'b1 : pos_ff + 1'b1;
      priority if (pos_next >= PosLast) begin
         falling_next = 1'b1;
      end else if (pos_next == '0) begin
         falling_next = 1'b0;
      end else begin
         falling_next = falling_ff;
      end
   end

   // State updates on a frame, then control register writes.
   always_comb begin
      mode_in      = mode_ff;
      color_in     = color_ff;
      bright_in    = bright_ff;
      power_in     = power_ff;
      last_time_in = last_time_ff;
      breath_in    = breath_ff;
      rising_in    = rising_ff;
      pos_in       = pos_ff;
      falling_in   = falling_ff;
      if (q_push) begin
         last_time_in = req_tdata;
         if (mode_ff == MODE_BREATH) begin
            breath_in = breath_next;
            rising_in = rising_next;
         end
         if (mode_ff == MODE_PULSE) begin
            pos_in     = pos_next;
            falling_in = falling_next;
         end
      end
      if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_EFFECT_MODE: begin
               mode_in      = mode_type'(csr_wdata[1:0]);
               breath_in    = BreathReset;
               rising_in    = 1'b1;
               last_time_in = '0;
            end
            CSR_BASE_COLOR: color_in  = csr_wdata[ColorW-1:0];
            CSR_BRIGHTNESS: bright_in = csr_wdata[ChanW-1:0];
            CSR_POWER_ON:   power_in  = csr_wdata[0];
         endcase
      end
   end

   // Frame descriptor for the back end.
   always_comb begin
      q_cmd.mode      = mode_ff;
      q_cmd.level     = breath_next;
      q_cmd.pulse_pos = pos_next;
      q_cmd.color     = color_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_SOLID;
         color_ff     <= '0;
         bright_ff    <= 8'd255;
         power_ff     <= 1'b1;
         last_time_ff <= '0;
         breath_ff    <= BreathReset;
         rising_ff    <= 1'b1;
         pos_ff       <= '0;
         falling_ff   <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         color_ff     <= color_in;
         bright_ff    <= bright_in;
         power_ff     <= power_in;
         last_time_ff <= last_time_in;
         breath_ff    <= breath_in;
         rising_ff    <= rising_in;
         pos_ff       <= pos_in;
         falling_ff   <= falling_in;
      end
   end

endmodule

[sv/lseg_back.sv]
module lseg_back #(
   parameter int NUM_LEDS = 6
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_valid,
   input  lseg_pkg::cmd_type                q_cmd,
   output logic                             q_pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [lseg_pkg::RspDataW-1:0]    rsp_tdata,
   output logic                             rsp_tlast
);
   import lseg_pkg::*;

   localparam int IdxW       = $clog2(NUM_LEDS);
   localparam int AccW       = ChanW + $clog2(NUM_LEDS + 1);
   localparam int RecipShift = AccW + $clog2(NUM_LEDS);
   localparam longint RecipVal = ((longint'(1) << RecipShift) + NUM_LEDS - 1) / NUM_LEDS;
   localparam int RecipW     = $clog2(RecipVal + 1);
   localparam logic [RecipW-1:0] Recip = RecipW'(RecipVal);
   localparam int ProdW      = AccW + RecipW;
   localparam logic [IdxW-1:0] IdxLast = IdxW'(NUM_LEDS - 1);

   // floor(c * level / 255), exact for 16-bit products.
   function automatic logic [ChanW-1:0] scale_255(input logic [ChanW-1:0] c,
                                                  input logic [LevelW-1:0] lvl);
      logic [16:0] prod;
      logic [16:0] sum;
      prod = 17'(c) * 17'(lvl);
      sum  = prod + (prod >> 8) + 17'd1;
      return sum[15:8];
   endfunction

   // floor(x / NUM_LEDS) by a rounded-up reciprocal.
   function automatic logic [ChanW-1:0] div_leds(input logic [AccW-1:0] x);
      logic [ProdW-1:0] prod;
      prod = ProdW'(x) * ProdW'(Recip);
      return prod[RecipShift +: ChanW];
   endfunction

   logic                busy_ff, busy_in;
   cmd_type             cmd_ff, cmd_in;
   logic [IdxW-1:0]     idx_ff, idx_in;
   logic [AccW-1:0]     acc_ff [3];
   logic [AccW-1:0]     acc_in [3];

   logic                rsp_valid_ff, rsp_valid_in;
   logic [PixW-1:0]     rsp_index_ff, rsp_index_in;
   logic [ChanW-1:0]    rsp_chan_ff [3];
   logic [ChanW-1:0]    rsp_chan_in [3];
   logic                rsp_last_ff, rsp_last_in;

   logic                out_free, fire, fire_last;
   logic [PixW-1:0]     idx_pix;
   logic [PixW-1:0]     gap;
   logic [LevelW-1:0]   level;
   logic [ChanW-1:0]    base [3];
   logic [ChanW-1:0]    q_base [3];
   logic [ChanW-1:0]    pix [3];

   // One pixel leaves per cycle while the output register can take it.
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign fire      = busy_ff && out_free;
   assign fire_last = fire && (idx_ff == IdxLast);
   assign q_pop     = q_valid && (!busy_ff || fire_last);

   assign base[0]   = cmd_ff.color[23:16];
   assign base[1]   = cmd_ff.color[15:8];
   assign base[2]   = cmd_ff.color[7:0];
   assign q_base[0] = q_cmd.color[23:16];
   assign q_base[1] = q_cmd.color[15:8];
   assign q_base[2] = q_cmd.color[7:0];

   // Pulse falloff from the distance to the center.
   always_comb begin
      idx_pix = PixW'(idx_ff);
      gap     = (idx_pix > cmd_ff.pulse_pos) ? idx_pix - cmd_ff.pulse_pos
                                             : cmd_ff.pulse_pos - idx_pix;
      unique case (gap)
         6'd0:    level = PulseLevel0;
         6'd1:    level = PulseLevel1;
         6'd2:    level = PulseLevel2;
         default: level = PulseLevelFar;
      endcase
   end

   // Pixel color for the current index.
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         unique case (cmd_ff.mode)
            MODE_SOLID:    pix[ch] = base[ch];
            MODE_BREATH:   pix[ch] = scale_255(base[ch], cmd_ff.level);
            MODE_GRADIENT: pix[ch] = div_leds(acc_ff[ch]);
            MODE_PULSE:    pix[ch] = scale_255(base[ch], level);
         endcase
      end
   end

   // Sequencer: load a frame, then step the index and the ramp sums.
   always_comb begin
      busy_in = busy_ff;
      cmd_in  = cmd_ff;
      idx_in  = idx_ff;
      for (int ch = 0; ch < 3; ch++) begin
         acc_in[ch] = acc_ff[ch];
      end
      if (fire) begin
         idx_in = idx_ff + 1'b1;
         for (int ch = 0; ch < 3; ch++) begin
            acc_in[ch] = acc_ff[ch] + AccW'(base[ch]);
         end
         if (fire_last) begin
            busy_in = 1'b0;
         end
      end
      if (q_pop) begin
         busy_in = 1'b1;
         cmd_in  = q_cmd;
         idx_in  = '0;
         for (int ch = 0; ch < 3; ch++) begin
            acc_in[ch] = AccW'(q_base[ch]);
         end
      end
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_index_in = rsp_index_ff;
      rsp_last_in  = rsp_last_ff;
      for (int ch = 0; ch < 3; ch++) begin
         rsp_chan_in[ch] = rsp_chan_ff[ch];
      end
      if (fire) begin
         rsp_valid_in = 1'b1;
         rsp_index_in = idx_pix;
         rsp_last_in  = (idx_ff == IdxLast);
         for (int ch = 0; ch < 3; ch++) begin
            rsp_chan_in[ch] = pix[ch];
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      idx_ff       <= idx_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
      for (int ch = 0; ch < 3; ch++) begin
         acc_ff[ch]      <= acc_in[ch];
         rsp_chan_ff[ch] <= rsp_chan_in[ch];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {2'b00, rsp_chan_ff[2], rsp_chan_ff[1], rsp_chan_ff[0], rsp_index_ff};

endmodule

[sv/led_strip_effect_generator_top.sv]
// The first pixel word of a frame passes the frame queue, the pixel sequencer's frame
// register and the output register. Time stamps are taken while the frame queue is not
// full; the pixel sequencer sends one pixel word per cycle while the output is not stalled,
// and a two-entry frame queue lets the next time stamps be taken meanwhile.
// Reset is synchronous and active high: settings and effect state return to their
// reset values, the frame queue empties and no pixel word is valid.
module led_strip_effect_generator_top #(
   parameter int NUM_LEDS = 6
) (
   input  logic                            clock,
   input  logic                            reset,
   // req_tdata: now_ms[31:0].
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [lseg_pkg::TimeW-1:0]      req_tdata,
   // rsp_tdata: pixel_index[5:0], red[13:6], green[21:14], blue[29:22], zero[31:30].
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [lseg_pkg::RspDataW-1:0]   rsp_tdata,
   output logic                            rsp_tlast,
   input  logic                            csr_we,
   input  logic [lseg_pkg::CsrAddrW-1:0]   csr_addr,
   input  logic [lseg_pkg::CsrDataW-1:0]   csr_wdata
);
   import lseg_pkg::*;

   logic    push, full, pop, pop_valid;
   cmd_type push_cmd, pop_cmd;

   // Time stamp check, settings and effect state.
   lseg_front #(.NUM_LEDS(NUM_LEDS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .q_full     (full),
      .q_push     (push),
      .q_cmd      (push_cmd)
   );

   // Frames waiting for the pixel sequencer.
   lseg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_cmd   (pop_cmd)
   );

   // Pixel sequencer and output register.
   lseg_back #(.NUM_LEDS(NUM_LEDS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (pop_valid),
      .q_cmd      (pop_cmd),
      .q_pop      (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[sv/lseg_checker.sv]
`include "led_strip_effect_generator_top_macros.svh"

module lseg_checker #(
   parameter int NUM_LEDS = 6
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [lseg_pkg::RspDataW-1:0]   rsp_tdata,
   input logic                            rsp_tlast
);

   // Out of reset the block is empty and ready.
   `LSEG_ASSERT_ALWAYS(a_reset_empty, clock, (!reset && $past(reset)) |-> (!rsp_tvalid && req_tready), "not empty after reset")

   // A stalled word stays valid and unchanged.
   `LSEG_ASSERT(a_hold_valid, clock, reset, (rsp_tvalid && !rsp_tready) |=> rsp_tvalid, "valid dropped under stall")
   `LSEG_ASSERT(a_hold_data, clock, reset, (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata), "data changed under stall")

   // The frame mark sits on the last LED and nowhere else.
   `LSEG_ASSERT(a_last_index, clock, reset, rsp_tvalid |-> (rsp_tlast == (rsp_tdata[5:0] == 6'(NUM_LEDS - 1))), "frame mark on wrong pixel")

   // Back-to-back words of one frame step the pixel index by one.
   `LSEG_ASSERT(a_index_step, clock, reset, (rsp_tvalid && $past(rsp_tvalid && rsp_tready && !rsp_tlast)) |-> (rsp_tdata[5:0] == $past(rsp_tdata[5:0]) + 6'd1), "pixel index out of order")

endmodule

bind led_strip_effect_generator_top lseg_checker #(.NUM_LEDS(NUM_LEDS)) u_checker (.*);
